/* design/q8dp_pkg.sv */
// Package for the q8 block dot product core: sizes, defaults and the queue entry type.
// Used by the front end, queue, back end and top level; depends on nothing else.
`default_nettype none

package q8dp_pkg;

    localparam int BLOCK_SIZE_DEF  = 32;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int ELEM_W   = 8;
    localparam int PROD_W   = 2 * ELEM_W;
    localparam int SCALE_W  = 32;
    localparam int FRAC_W   = 24;
    localparam int SPROD_W  = 2 * SCALE_W - FRAC_W;
    localparam int ACC_W    = 64;
    // Block sum width for the largest allowed block size of 32 elements.
    localparam int SUM_W_MAX = 21;
    // Signed product of the scale product (made non-negative) and a block sum.
    localparam int TERM_W   = SPROD_W + 1 + SUM_W_MAX;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // One closed block, handed from the front end to the back end.
    typedef struct packed {
        logic                        last;
        logic [SCALE_W-1:0]          b_scale;
        logic [SCALE_W-1:0]          a_scale;
        logic signed [SUM_W_MAX-1:0] sum;
    } block_entry_t;

endpackage

`default_nettype wire

/* design/q8dp_front.sv */
// Front end of the q8 block dot product core: accepts element pairs, sums the
// int8 products of a block and pushes one entry per closed block. Uses q8dp_pkg.
`default_nettype none

module q8dp_front #(
    parameter int BLOCK_SIZE = q8dp_pkg::BLOCK_SIZE_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic signed [q8dp_pkg::ELEM_W-1:0]  a_val,
    input  wire logic signed [q8dp_pkg::ELEM_W-1:0]  b_val,
    input  wire logic [q8dp_pkg::SCALE_W-1:0]    a_scale,
    input  wire logic [q8dp_pkg::SCALE_W-1:0]    b_scale,
    input  wire logic                            vector_end,
    input  wire logic                            q_full,
    output logic                                 q_push,
    output q8dp_pkg::block_entry_t               q_entry
);

    localparam int SUM_W = q8dp_pkg::PROD_W + $clog2(BLOCK_SIZE);
    localparam int CNT_W = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;

    logic signed [SUM_W-1:0]            sum_reg, sum_next, sum_upd;
    logic [CNT_W-1:0]                   count_reg, count_next;
    logic signed [q8dp_pkg::PROD_W-1:0] prod;
    logic                               accept, closing;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign prod     = a_val * b_val;
    assign sum_upd  = sum_reg + SUM_W'(prod);
    assign closing  = vector_end || (count_reg == CNT_W'(BLOCK_SIZE - 1));

    always_comb begin
        sum_next   = sum_reg;
        count_next = count_reg;
        if (accept) begin
            if (closing) begin
                sum_next   = '0;
                count_next = '0;
            end else begin
                sum_next   = sum_upd;
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    assign q_push          = accept && closing;
    assign q_entry.last    = vector_end;
    assign q_entry.a_scale = a_scale;
    assign q_entry.b_scale = b_scale;
    assign q_entry.sum     = q8dp_pkg::SUM_W_MAX'(sum_upd);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            count_reg <= '0;
        end else begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

/* design/q8dp_queue.sv */
// Short register queue of closed-block entries between front and back end.
// Uses q8dp_pkg for the entry type.
`default_nettype none

module q8dp_queue #(
    parameter int DEPTH = q8dp_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   push,
    input  wire q8dp_pkg::block_entry_t push_entry,
    input  wire logic                   pop,
    output q8dp_pkg::block_entry_t      head,
    output logic                        empty,
    output logic                        full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    q8dp_pkg::block_entry_t slots_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]       count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign head  = slots_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* design/q8dp_back.sv */
// Back end of the q8 block dot product core: scales each block sum, adds it to
// the saturating accumulator and holds the result register. Uses q8dp_pkg.
`default_nettype none

module q8dp_back (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire q8dp_pkg::block_entry_t       head,
    input  wire logic                         q_empty,
    output logic                              q_pop,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [q8dp_pkg::ACC_W-1:0] dot_value,
    output logic                              saturated
);

    localparam int ACC_W = q8dp_pkg::ACC_W;
    localparam int TERM_W = q8dp_pkg::TERM_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_TERM = 2'd1;
    localparam logic [1:0] ST_ACC  = 2'd2;

    logic [1:0] state_reg, state_next;

    logic [q8dp_pkg::SPROD_W-1:0]          sp_reg;
    logic signed [q8dp_pkg::SUM_W_MAX-1:0] sum_reg;
    logic                                  last_reg;
    logic signed [TERM_W-1:0]              term_reg, term_next;
    logic signed [ACC_W-1:0]               acc_reg, acc_new;
    logic                                  flag_reg, flag_new;
    logic [2*q8dp_pkg::SCALE_W-1:0]        scale_prod;
    logic signed [ACC_W:0]                 acc_wide;
    logic                                  ovf, finish;

    logic                    out_valid_reg;
    logic signed [ACC_W-1:0] out_data_reg;
    logic                    out_sat_reg;

    assign scale_prod = (2*q8dp_pkg::SCALE_W)'(head.a_scale)
                      * (2*q8dp_pkg::SCALE_W)'(head.b_scale);
    assign term_next  = $signed({1'b0, sp_reg}) * sum_reg;

    // Wide add: the top two bits disagree exactly when the signed add overflows.
    assign acc_wide = {acc_reg[ACC_W-1], acc_reg}
                    + (ACC_W + 1)'(term_reg);
    assign ovf      = acc_wide[ACC_W] ^ acc_wide[ACC_W-1];
    assign acc_new  = ovf ? (term_reg[TERM_W-1] ? q8dp_pkg::ACC_MIN : q8dp_pkg::ACC_MAX)
                          : acc_wide[ACC_W-1:0];
    assign flag_new = flag_reg | ovf;

    // A closing vector needs the result register free before it can finish.
    assign finish = (state_reg == ST_ACC) && (!last_reg || !out_valid_reg || out_ready);
    assign q_pop  = (state_reg == ST_IDLE) && !q_empty;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    state_next = ST_TERM;
                end
            end
            ST_TERM: begin
                state_next = ST_ACC;
            end
            ST_ACC: begin
                if (finish) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            sp_reg   <= scale_prod[2*q8dp_pkg::SCALE_W-1:q8dp_pkg::FRAC_W];
            sum_reg  <= head.sum;
            last_reg <= head.last;
        end
        if (state_reg == ST_TERM) begin
            term_reg <= term_next;
        end
        if (finish && last_reg) begin
            out_data_reg <= acc_new;
            out_sat_reg  <= flag_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (finish) begin
                if (last_reg) begin
                    acc_reg  <= '0;
                    flag_reg <= 1'b0;
                end else begin
                    acc_reg  <= acc_new;
                    flag_reg <= flag_new;
                end
            end
            if (finish && last_reg) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign dot_value = out_data_reg;
    assign saturated = out_sat_reg;

endmodule

`default_nettype wire

/* design/q8_block_dot_product_core.sv */
// Top level of the q8 block dot product core: front end, block queue, back end.
// Depends on q8dp_pkg, q8dp_front, q8dp_queue and q8dp_back.
//
// Usage: each input item carries one int8 element pair of two block-quantized
// vectors plus both blocks' scales (unsigned, 24 fraction bits); s_tlast marks
// the last pair of the vectors. Products are summed over blocks of BLOCK_SIZE
// items; the scales on the item that closes a block are the ones used.
// At s_tlast one result item leaves on the m_ channel: the 64-bit signed dot
// product (24 fraction bits) in m_tdata and the sticky saturation flag in m_tuser.
// Throughput: the front end takes one item per cycle while the queue has room.
// Every closed block passes through the back end's scale multiply, block
// multiply and saturating add, so with blocks of three or more items the input
// runs at one item per cycle; shorter blocks fill the block queue
// (QUEUE_DEPTH entries) and s_tready drops. The result is registered at the
// saturating add of the vector's closing block, after it has left the queue.
// Reset (aresetn low, synchronous) clears the block sum, element count,
// accumulator, flag, queue pointers and count, and the result valid bit. When
// the receiver stalls, the result is held in m_tdata/m_tuser; the next vector's
// blocks keep queueing until its own closing block needs the result register.
`default_nettype none

module q8_block_dot_product_core #(
    parameter int BLOCK_SIZE  = q8dp_pkg::BLOCK_SIZE_DEF,
    parameter int QUEUE_DEPTH = q8dp_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,   // a_val[7:0], b_val[15:8], a_scale[47:16], b_scale[79:48]
    input  wire logic        s_tlast,   // vector_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // dot_value[63:0]
    output logic [0:0]       m_tuser    // saturated[0]
);

    q8dp_pkg::block_entry_t push_entry, head;
    logic                   q_push, q_pop, q_empty, q_full;
    logic signed [q8dp_pkg::ACC_W-1:0] dot_value;
    logic                   saturated;

    q8dp_front #(
        .BLOCK_SIZE (BLOCK_SIZE)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .a_val      ($signed(s_tdata[7:0])),
        .b_val      ($signed(s_tdata[15:8])),
        .a_scale    (s_tdata[47:16]),
        .b_scale    (s_tdata[79:48]),
        .vector_end (s_tlast),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_entry    (push_entry)
    );

    q8dp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head       (head),
        .empty      (q_empty),
        .full       (q_full)
    );

    q8dp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .dot_value (dot_value),
        .saturated (saturated)
    );

    assign m_tdata    = dot_value;
    assign m_tuser[0] = saturated;

endmodule

`default_nettype wire

/* design/q8dp_checker.sv */
// Port-level checker for the q8 block dot product core, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module q8dp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata,
    input wire logic [0:0]  m_tuser
);

    // Vectors whose closing item has been accepted but whose result is not yet taken.
    logic [7:0] pending_reg;
    logic       in_last, out_take;

    assign in_last  = s_tvalid && s_tready && s_tlast;
    assign out_take = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else if (in_last && !out_take) begin
            pending_reg <= pending_reg + 8'd1;
        end else if (out_take && !in_last) begin
            pending_reg <= pending_reg - 8'd1;
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_result_has_vector: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pending_reg != 8'd0)
        else $error("result without a closed vector");

    a_no_fast_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(pending_reg) != 8'd0)
        else $error("result appeared in the cycle of its closing item");

endmodule

bind q8_block_dot_product_core q8dp_checker u_q8dp_checker (.*);

`default_nettype wire
